// File: hdl/sws_pkg.sv
// shared types, codes and constants of the shell word splitter
package sws_pkg;

   localparam int WORD_COUNT_BITS = 16;
   localparam int MAX_WORDS_BITS  = 16;
   localparam logic [MAX_WORDS_BITS-1:0] MAX_WORDS_RESET = 16'd512;

   // quote modes
   localparam logic [1:0] QM_NONE   = 2'd0;
   localparam logic [1:0] QM_SINGLE = 2'd1;
   localparam logic [1:0] QM_DOUBLE = 2'd2;
   localparam logic [1:0] QM_DOLLAR = 2'd3;

   // escape phases
   localparam logic [2:0] PH_NONE  = 3'd0;
   localparam logic [2:0] PH_UNQ   = 3'd1;
   localparam logic [2:0] PH_DQ    = 3'd2;
   localparam logic [2:0] PH_DS    = 3'd3;
   localparam logic [2:0] PH_CTRL  = 3'd4;
   localparam logic [2:0] PH_CTRLB = 3'd5;
   localparam logic [2:0] PH_HEX   = 3'd6;
   localparam logic [2:0] PH_OCT   = 3'd7;

   // error codes
   localparam logic [2:0] ERR_NONE      = 3'd0;
   localparam logic [2:0] ERR_ESCAPE    = 3'd1;
   localparam logic [2:0] ERR_HEX       = 3'd2;
   localparam logic [2:0] ERR_OCTAL     = 3'd3;
   localparam logic [2:0] ERR_OCT_RANGE = 3'd4;
   localparam logic [2:0] ERR_WORDS     = 3'd5;

   // characters
   localparam logic [7:0] CH_ESC    = 8'h1b;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_NL     = 8'h0a;
   localparam logic [7:0] CH_DOLLAR = 8'h24;
   localparam logic [7:0] CH_SQUOTE = 8'h27;
   localparam logic [7:0] CH_DQUOTE = 8'h22;
   localparam logic [7:0] CH_BSLASH = 8'h5c;

   typedef struct packed {
      logic [1:0] quote_mode;
      logic       dollar_held;
      logic [2:0] escape_phase;
      logic [1:0] digits_left;
      logic [8:0] escape_value;
      logic       discard_line;
   } line_state_type;

   localparam line_state_type LINE_IDLE = '{
      quote_mode:   QM_NONE,
      dollar_held:  1'b0,
      escape_phase: PH_NONE,
      digits_left:  2'd0,
      escape_value: 9'd0,
      discard_line: 1'b0
   };

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       word_end;
      logic [2:0] error_code;
      logic       last_of_input;
   } result_type;

endpackage

// File: hdl/sws_step.sv
// next line state and up to two result beats for one input byte
module sws_step #(
   parameter int WordCountBits = sws_pkg::WORD_COUNT_BITS
) (
   input  sws_pkg::line_state_type                state_cur,
   input  logic [WordCountBits-1:0]               count_cur,
   input  logic [7:0]                             in_byte,
   input  logic                                   line_end,
   input  logic [sws_pkg::MAX_WORDS_BITS-1:0]     max_words,
   output sws_pkg::line_state_type                state_nxt,
   output logic [WordCountBits-1:0]               count_nxt,
   output sws_pkg::result_type [1:0]              results,
   output logic [1:0]                             result_count
);

   localparam int CmpBits = (WordCountBits > sws_pkg::MAX_WORDS_BITS) ?
                            WordCountBits : sws_pkg::MAX_WORDS_BITS;

   typedef struct packed {
      logic [1:0]                     rn;
      sws_pkg::result_type [1:0]      res;
   } acc_type;

   function automatic acc_type push_byte(acc_type a, logic [7:0] b);
      acc_type r;
      r = a;
      if (r.rn != 2'd2) begin
         r.res[r.rn[0]].out_byte   = b;
         r.res[r.rn[0]].byte_valid = 1'b1;
         r.rn = r.rn + 2'd1;
      end
      return r;
   endfunction

   function automatic acc_type push_end(acc_type a);
      acc_type r;
      r = a;
      if (r.rn != 2'd0 && !r.res[r.rn[1]].word_end &&
          r.res[r.rn[1]].error_code == sws_pkg::ERR_NONE) begin
         r.res[r.rn[1]].word_end = 1'b1;
      end else if (r.rn != 2'd2) begin
         r.res[r.rn[0]].word_end = 1'b1;
         r.rn = r.rn + 2'd1;
      end
      return r;
   endfunction

   function automatic acc_type push_err(acc_type a, logic [2:0] code);
      acc_type r;
      r = a;
      if (r.rn != 2'd0 && r.res[r.rn[1]].error_code == sws_pkg::ERR_NONE) begin
         r.res[r.rn[1]].error_code = code;
      end else if (r.rn != 2'd2) begin
         r.res[r.rn[0]].error_code = code;
         r.rn = r.rn + 2'd1;
      end
      return r;
   endfunction

   function automatic logic [4:0] hex_val(logic [7:0] b);
      logic [7:0] t;
      t = 8'd0;
      if (b >= "0" && b <= "9") begin
         t = b - 8'd48;
         return {1'b1, t[3:0]};
      end
      if (b >= "a" && b <= "f") begin
         t = b - 8'd87;
         return {1'b1, t[3:0]};
      end
      if (b >= "A" && b <= "F") begin
         t = b - 8'd55;
         return {1'b1, t[3:0]};
      end
      return 5'd0;
   endfunction

   function automatic logic [7:0] ctrl_of(logic [7:0] b);
      logic [7:0] t;
      t = b;
      if (b >= "a" && b <= "z") begin
         t = b - 8'd32;
      end
      return t ^ 8'h40;
   endfunction

   always_comb begin
      sws_pkg::line_state_type s;
      logic [WordCountBits-1:0] cnt;
      acc_type acc;
      logic zero;
      logic last;
      logic done;
      logic [4:0] hv;
      logic [CmpBits-1:0] cnt_ext;
      logic [CmpBits-1:0] max_ext;

      s    = state_cur;
      cnt  = count_cur;
      acc  = '0;
      zero = (in_byte == 8'd0);
      last = zero || line_end;
      done = 1'b0;
      hv   = hex_val(in_byte);
      cnt_ext = '0;
      max_ext = CmpBits'(max_words);

      if (!s.discard_line) begin
         if (!zero) begin
            if (s.dollar_held) begin
               s.dollar_held = 1'b0;
               if (in_byte == sws_pkg::CH_SQUOTE) begin
                  s.quote_mode = sws_pkg::QM_DOLLAR;
                  done = 1'b1;
               end else begin
                  acc = push_byte(acc, sws_pkg::CH_DOLLAR);
               end
            end
            if (!done) begin
               done = 1'b1;
               unique case (s.escape_phase)
                  sws_pkg::PH_UNQ: begin
                     s.escape_phase = sws_pkg::PH_NONE;
                     if (in_byte != sws_pkg::CH_NL) acc = push_byte(acc, in_byte);
                  end
                  sws_pkg::PH_DQ: begin
                     s.escape_phase = sws_pkg::PH_NONE;
                     if (in_byte == sws_pkg::CH_DQUOTE) begin
                        acc = push_byte(acc, in_byte);
                     end else if (in_byte != sws_pkg::CH_NL) begin
                        acc = push_err(acc, sws_pkg::ERR_ESCAPE);
                        s.discard_line = 1'b1;
                     end
                  end
                  sws_pkg::PH_DS: begin
                     s.escape_phase = sws_pkg::PH_NONE;
                     case (in_byte)
                        sws_pkg::CH_DQUOTE, sws_pkg::CH_SQUOTE, sws_pkg::CH_BSLASH:
                           acc = push_byte(acc, in_byte);
                        "a": acc = push_byte(acc, 8'h07);
                        "b": acc = push_byte(acc, 8'h08);
                        "e": acc = push_byte(acc, sws_pkg::CH_ESC);
                        "f": acc = push_byte(acc, 8'h0c);
                        "n": acc = push_byte(acc, sws_pkg::CH_NL);
                        "r": acc = push_byte(acc, 8'h0d);
                        "t": acc = push_byte(acc, sws_pkg::CH_TAB);
                        "v": acc = push_byte(acc, 8'h0b);
                        "c": s.escape_phase = sws_pkg::PH_CTRL;
                        "x": begin
                           s.escape_phase = sws_pkg::PH_HEX;
                           s.escape_value = 9'd0;
                           s.digits_left  = 2'd2;
                        end
                        default: begin
                           if (in_byte >= "0" && in_byte <= "7") begin
                              s.escape_phase = sws_pkg::PH_OCT;
                              s.escape_value = {6'd0, in_byte[2:0]};
                              s.digits_left  = 2'd2;
                           end else begin
                              acc = push_err(acc, sws_pkg::ERR_ESCAPE);
                              s.discard_line = 1'b1;
                           end
                        end
                     endcase
                  end
                  sws_pkg::PH_CTRL: begin
                     if (in_byte == sws_pkg::CH_BSLASH) begin
                        s.escape_phase = sws_pkg::PH_CTRLB;
                     end else begin
                        s.escape_phase = sws_pkg::PH_NONE;
                        acc = push_byte(acc, ctrl_of(in_byte));
                     end
                  end
                  sws_pkg::PH_CTRLB: begin
                     s.escape_phase = sws_pkg::PH_NONE;
                     acc = push_byte(acc, ctrl_of(in_byte));
                  end
                  sws_pkg::PH_HEX, sws_pkg::PH_OCT: begin
                     if (s.escape_phase == sws_pkg::PH_HEX && !hv[4]) begin
                        s.escape_phase = sws_pkg::PH_NONE;
                        acc = push_err(acc, sws_pkg::ERR_HEX);
                        s.discard_line = 1'b1;
                     end else if (s.escape_phase == sws_pkg::PH_OCT &&
                                  (in_byte < "0" || in_byte > "7")) begin
                        s.escape_phase = sws_pkg::PH_NONE;
                        acc = push_err(acc, sws_pkg::ERR_OCTAL);
                        s.discard_line = 1'b1;
                     end else begin
                        if (s.escape_phase == sws_pkg::PH_HEX)
                           s.escape_value = {s.escape_value[4:0], hv[3:0]};
                        else
                           s.escape_value = {s.escape_value[5:0], in_byte[2:0]};
                        if (s.digits_left != 2'd0) s.digits_left = s.digits_left - 2'd1;
                        if (s.digits_left == 2'd0) begin
                           s.escape_phase = sws_pkg::PH_NONE;
                           if (s.escape_value > 9'd255) begin
                              acc = push_err(acc, sws_pkg::ERR_OCT_RANGE);
                              s.discard_line = 1'b1;
                           end else begin
                              acc = push_byte(acc, s.escape_value[7:0]);
                           end
                        end
                     end
                  end
                  default: done = 1'b0;
               endcase
            end
            if (!done) begin
               case (s.quote_mode)
                  sws_pkg::QM_SINGLE: begin
                     if (in_byte == sws_pkg::CH_SQUOTE) s.quote_mode = sws_pkg::QM_NONE;
                     else acc = push_byte(acc, in_byte);
                  end
                  sws_pkg::QM_DOUBLE: begin
                     if (in_byte == sws_pkg::CH_DQUOTE) s.quote_mode = sws_pkg::QM_NONE;
                     else if (in_byte == sws_pkg::CH_BSLASH) s.escape_phase = sws_pkg::PH_DQ;
                     else acc = push_byte(acc, in_byte);
                  end
                  sws_pkg::QM_DOLLAR: begin
                     if (in_byte == sws_pkg::CH_SQUOTE) s.quote_mode = sws_pkg::QM_NONE;
                     else if (in_byte == sws_pkg::CH_BSLASH) s.escape_phase = sws_pkg::PH_DS;
                     else acc = push_byte(acc, in_byte);
                  end
                  default: begin
                     if (in_byte == sws_pkg::CH_SQUOTE) begin
                        s.quote_mode = sws_pkg::QM_SINGLE;
                     end else if (in_byte == sws_pkg::CH_DQUOTE) begin
                        s.quote_mode = sws_pkg::QM_DOUBLE;
                     end else if (in_byte == sws_pkg::CH_DOLLAR) begin
                        s.dollar_held = 1'b1;
                     end else if (in_byte == sws_pkg::CH_BSLASH) begin
                        s.escape_phase = sws_pkg::PH_UNQ;
                     end else if (in_byte == sws_pkg::CH_SPACE || in_byte == sws_pkg::CH_TAB ||
                                  in_byte == sws_pkg::CH_NL) begin
                        if (cnt != {WordCountBits{1'b1}}) cnt = cnt + WordCountBits'(1);
                        cnt_ext = CmpBits'(cnt);
                        if (cnt_ext >= max_ext) begin
                           acc = push_err(acc, sws_pkg::ERR_WORDS);
                           s.discard_line = 1'b1;
                        end else begin
                           acc = push_end(acc);
                        end
                     end else begin
                        acc = push_byte(acc, in_byte);
                     end
                  end
               endcase
            end
         end
         if (last && !s.discard_line) begin
            if (s.dollar_held) begin
               s.dollar_held = 1'b0;
               acc = push_byte(acc, sws_pkg::CH_DOLLAR);
            end
            if (s.escape_phase == sws_pkg::PH_HEX) begin
               acc = push_err(acc, sws_pkg::ERR_HEX);
            end else if (s.escape_phase == sws_pkg::PH_OCT) begin
               acc = push_err(acc, sws_pkg::ERR_OCTAL);
            end else if (s.escape_phase != sws_pkg::PH_NONE) begin
               acc = push_err(acc, sws_pkg::ERR_ESCAPE);
            end else begin
               if (cnt != {WordCountBits{1'b1}}) cnt = cnt + WordCountBits'(1);
               cnt_ext = CmpBits'(cnt);
               if (cnt_ext >= max_ext) acc = push_err(acc, sws_pkg::ERR_WORDS);
               else acc = push_end(acc);
            end
         end
      end

      if (last) begin
         s   = sws_pkg::LINE_IDLE;
         cnt = '0;
      end
      if (acc.rn != 2'd0) acc.res[acc.rn[1]].last_of_input = 1'b1;

      state_nxt    = s;
      count_nxt    = cnt;
      results      = acc.res;
      result_count = acc.rn;
   end

endmodule

// File: hdl/shell_word_splitter.sv
// shell word splitter: input register, per-byte step logic, two-entry result queue
// the step logic works on the input register; its result beats are registered into the queue
// throughput: one byte per cycle while each byte gives at most one beat and beats are taken;
// a byte with two beats can hold the input until the two-entry queue has room for both
// reset: line state, word count and queue clear; max_words returns to 512
module shell_word_splitter #(
   parameter int WORD_COUNT_BITS = sws_pkg::WORD_COUNT_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [sws_pkg::MAX_WORDS_BITS-1:0] csr_max_words,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [7:0]                         req_in_byte,
   input  logic                               req_line_end,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [7:0]                         rsp_out_byte,
   output logic                               rsp_byte_valid,
   output logic                               rsp_word_end,
   output logic [2:0]                         rsp_error_code,
   output logic                               rsp_last_of_input
);

   logic [sws_pkg::MAX_WORDS_BITS-1:0] max_words_ff;
   logic                               in_valid_ff, in_valid_in;
   logic [7:0]                         in_byte_ff;
   logic                               in_end_ff;
   sws_pkg::line_state_type            state_ff, state_in;
   logic [WORD_COUNT_BITS-1:0]         count_ff, count_in;
   sws_pkg::result_type [1:0]          queue_ff, queue_in;
   logic [1:0]                         queue_cnt_ff, queue_cnt_in;

   sws_pkg::result_type [1:0]          step_res;
   logic [1:0]                         step_cnt;
   logic                               pop;
   logic                               fire;
   logic [1:0]                         keep;
   logic [1:0]                         space;

   sws_step #(
      .WordCountBits(WORD_COUNT_BITS)
   ) u_step (
      .state_cur    (state_ff),
      .count_cur    (count_ff),
      .in_byte      (in_byte_ff),
      .line_end     (in_end_ff),
      .max_words    (max_words_ff),
      .state_nxt    (state_in),
      .count_nxt    (count_in),
      .results      (step_res),
      .result_count (step_cnt)
   );

   assign csr_ready = !reset;

   assign rsp_valid         = (queue_cnt_ff != 2'd0);
   assign rsp_out_byte      = queue_ff[0].out_byte;
   assign rsp_byte_valid    = queue_ff[0].byte_valid;
   assign rsp_word_end      = queue_ff[0].word_end;
   assign rsp_error_code    = queue_ff[0].error_code;
   assign rsp_last_of_input = queue_ff[0].last_of_input;

   always_comb begin
      pop   = rsp_valid && rsp_ready;
      keep  = queue_cnt_ff - {1'b0, pop};
      space = 2'd2 - keep;
      fire  = in_valid_ff && (step_cnt <= space);
      req_ready   = !reset && (!in_valid_ff || fire);
      in_valid_in = req_ready ? req_valid : in_valid_ff;

      queue_in[0] = pop ? queue_ff[1] : queue_ff[0];
      queue_in[1] = queue_ff[1];
      if (fire && step_cnt != 2'd0) begin
         if (keep == 2'd0) queue_in[0] = step_res[0];
         else queue_in[1] = step_res[0];
         if (step_cnt == 2'd2) queue_in[1] = step_res[1];
      end
      queue_cnt_in = keep + (fire ? step_cnt : 2'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_words_ff <= sws_pkg::MAX_WORDS_RESET;
         in_valid_ff  <= 1'b0;
         state_ff     <= sws_pkg::LINE_IDLE;
         count_ff     <= '0;
         queue_cnt_ff <= 2'd0;
      end else begin
         if (csr_valid && csr_ready) max_words_ff <= csr_max_words;
         in_valid_ff  <= in_valid_in;
         queue_cnt_ff <= queue_cnt_in;
         if (fire) begin
            state_ff <= state_in;
            count_ff <= count_in;
         end
      end
   end

   // payload, no reset
   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_byte_ff <= req_in_byte;
         in_end_ff  <= req_line_end;
      end
      queue_ff <= queue_in;
   end

endmodule

// File: dv/shell_word_splitter_tb.sv
// self-checking testbench for the shell word splitter: random lines, word and escape checks
`timescale 1ns / 1ps

module shell_word_splitter_tb;

   localparam int STALL_LIMIT = 2000;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       line_end;
   } req_beat_type;

   typedef enum int {
      TOK_PLAIN, TOK_SPACE, TOK_SINGLE, TOK_DOUBLE, TOK_ANSI,
      TOK_BSLASH, TOK_DOLLAR, TOK_NOISE, TOK_CUT
   } token_kind_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [15:0] csr_max_words = 16'd0;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte = 8'd0;
   logic        req_line_end = 1'b0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic        rsp_byte_valid;
   logic        rsp_word_end;
   logic [2:0]  rsp_error_code;
   logic        rsp_last_of_input;

   shell_word_splitter DUT (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_max_words     (csr_max_words),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_in_byte       (req_in_byte),
      .req_line_end      (req_line_end),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_out_byte      (rsp_out_byte),
      .rsp_byte_valid    (rsp_byte_valid),
      .rsp_word_end      (rsp_word_end),
      .rsp_error_code    (rsp_error_code),
      .rsp_last_of_input (rsp_last_of_input)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   req_beat_type         pending[$];
   sws_pkg::result_type  expected_beats[$];
   int                   errors = 0;
   int                   beats_in = 0;
   int                   hold_left = 0;
   int                   idle_cycles = 0;
   int                   req_gap = 0;
   int                   rsp_gap = 0;
   logic                 calm = 1'b0;

   // splitter state as the block should hold it
   logic [1:0]                          quote_st = sws_pkg::QM_NONE;
   logic                                dollar_st = 1'b0;
   logic [2:0]                          esc_st = sws_pkg::PH_NONE;
   logic [1:0]                          digits_st = 2'd0;
   logic [8:0]                          value_st = 9'd0;
   logic [sws_pkg::WORD_COUNT_BITS-1:0] words_st = '0;
   logic                                drop_st = 1'b0;
   logic [15:0]                         limit_words = sws_pkg::MAX_WORDS_RESET;
   sws_pkg::result_type                 beat_buf[2];
   int                                  beat_n;

   function automatic void add_byte(input logic [7:0] b);
      if (beat_n < 2) begin
         beat_buf[beat_n].out_byte = b;
         beat_buf[beat_n].byte_valid = 1'b1;
         beat_n++;
      end
   endfunction

   function automatic void add_error(input logic [2:0] code);
      if (beat_n > 0 && beat_buf[beat_n-1].error_code == sws_pkg::ERR_NONE) begin
         beat_buf[beat_n-1].error_code = code;
      end else if (beat_n < 2) begin
         beat_buf[beat_n].error_code = code;
         beat_n++;
      end
      drop_st = 1'b1;
   endfunction

   function automatic void close_word();
      if (words_st != '1) words_st++;
      if (words_st >= limit_words) begin
         add_error(sws_pkg::ERR_WORDS);
      end else if (beat_n > 0 && !beat_buf[beat_n-1].word_end &&
                   beat_buf[beat_n-1].error_code == sws_pkg::ERR_NONE) begin
         beat_buf[beat_n-1].word_end = 1'b1;
      end else if (beat_n < 2) begin
         beat_buf[beat_n].word_end = 1'b1;
         beat_n++;
      end
   endfunction

   function automatic logic [7:0] ctrl_char(input logic [7:0] b);
      logic [7:0] c;
      c = b;
      if (c >= "a" && c <= "z") c = c - 8'd32;
      return c ^ 8'h40;
   endfunction

   function automatic void digit_done();
      if (digits_st != 0) digits_st--;
      if (digits_st == 0) begin
         esc_st = sws_pkg::PH_NONE;
         if (value_st > 9'd255) add_error(sws_pkg::ERR_OCT_RANGE);
         else add_byte(value_st[7:0]);
      end
   endfunction

   function automatic void predict_beats(input logic [7:0] b, input logic fin);
      logic       last;
      logic       skip;
      logic       hex_ok;
      logic [3:0] dig;
      for (int k = 0; k < 2; k++) beat_buf[k] = '0;
      beat_n = 0;
      last = (b == 8'h00) || fin;
      skip = 1'b0;
      hex_ok = 1'b1;
      dig = 4'd0;
      if (!drop_st && b != 8'h00) begin
         if (dollar_st) begin
            dollar_st = 1'b0;
            if (b == sws_pkg::CH_SQUOTE) begin
               quote_st = sws_pkg::QM_DOLLAR;
               skip = 1'b1;
            end else begin
               add_byte(sws_pkg::CH_DOLLAR);
            end
         end
         if (!skip) begin
            case (esc_st)
               sws_pkg::PH_UNQ: begin
                  esc_st = sws_pkg::PH_NONE;
                  if (b != sws_pkg::CH_NL) add_byte(b);
               end
               sws_pkg::PH_DQ: begin
                  esc_st = sws_pkg::PH_NONE;
                  if (b == sws_pkg::CH_DQUOTE) add_byte(b);
                  else if (b != sws_pkg::CH_NL) add_error(sws_pkg::ERR_ESCAPE);
               end
               sws_pkg::PH_DS: begin
                  esc_st = sws_pkg::PH_NONE;
                  case (b)
                     sws_pkg::CH_DQUOTE, sws_pkg::CH_SQUOTE, sws_pkg::CH_BSLASH: add_byte(b);
                     "a": add_byte(8'h07);
                     "b": add_byte(8'h08);
                     "e": add_byte(sws_pkg::CH_ESC);
                     "f": add_byte(8'h0c);
                     "n": add_byte(sws_pkg::CH_NL);
                     "r": add_byte(8'h0d);
                     "t": add_byte(sws_pkg::CH_TAB);
                     "v": add_byte(8'h0b);
                     "c": esc_st = sws_pkg::PH_CTRL;
                     "x": begin
                        esc_st = sws_pkg::PH_HEX;
                        value_st = 9'd0;
                        digits_st = 2'd2;
                     end
                     default: begin
                        if (b >= "0" && b <= "7") begin
                           esc_st = sws_pkg::PH_OCT;
                           value_st = {6'd0, b[2:0]};
                           digits_st = 2'd2;
                        end else begin
                           add_error(sws_pkg::ERR_ESCAPE);
                        end
                     end
                  endcase
               end
               sws_pkg::PH_CTRL: begin
                  if (b == sws_pkg::CH_BSLASH) begin
                     esc_st = sws_pkg::PH_CTRLB;
                  end else begin
                     esc_st = sws_pkg::PH_NONE;
                     add_byte(ctrl_char(b));
                  end
               end
               sws_pkg::PH_CTRLB: begin
                  esc_st = sws_pkg::PH_NONE;
                  add_byte(ctrl_char(b));
               end
               sws_pkg::PH_HEX: begin
                  if (b >= "0" && b <= "9") dig = 4'(b - "0");
                  else if (b >= "a" && b <= "f") dig = 4'(b - "a" + 8'd10);
                  else if (b >= "A" && b <= "F") dig = 4'(b - "A" + 8'd10);
                  else hex_ok = 1'b0;
                  if (!hex_ok) begin
                     esc_st = sws_pkg::PH_NONE;
                     add_error(sws_pkg::ERR_HEX);
                  end else begin
                     value_st = {value_st[4:0], dig};
                     digit_done();
                  end
               end
               sws_pkg::PH_OCT: begin
                  if (b < "0" || b > "7") begin
                     esc_st = sws_pkg::PH_NONE;
                     add_error(sws_pkg::ERR_OCTAL);
                  end else begin
                     value_st = {value_st[5:0], b[2:0]};
                     digit_done();
                  end
               end
               default: begin
                  case (quote_st)
                     sws_pkg::QM_SINGLE: begin
                        if (b == sws_pkg::CH_SQUOTE) quote_st = sws_pkg::QM_NONE;
                        else add_byte(b);
                     end
                     sws_pkg::QM_DOUBLE: begin
                        if (b == sws_pkg::CH_DQUOTE) quote_st = sws_pkg::QM_NONE;
                        else if (b == sws_pkg::CH_BSLASH) esc_st = sws_pkg::PH_DQ;
                        else add_byte(b);
                     end
                     sws_pkg::QM_DOLLAR: begin
                        if (b == sws_pkg::CH_SQUOTE) quote_st = sws_pkg::QM_NONE;
                        else if (b == sws_pkg::CH_BSLASH) esc_st = sws_pkg::PH_DS;
                        else add_byte(b);
                     end
                     default: begin
                        if (b == sws_pkg::CH_SQUOTE) quote_st = sws_pkg::QM_SINGLE;
                        else if (b == sws_pkg::CH_DQUOTE) quote_st = sws_pkg::QM_DOUBLE;
                        else if (b == sws_pkg::CH_DOLLAR) dollar_st = 1'b1;
                        else if (b == sws_pkg::CH_BSLASH) esc_st = sws_pkg::PH_UNQ;
                        else if (b == sws_pkg::CH_SPACE || b == sws_pkg::CH_TAB ||
                                 b == sws_pkg::CH_NL) close_word();
                        else add_byte(b);
                     end
                  endcase
               end
            endcase
         end
      end
      if (last && !drop_st) begin
         if (dollar_st) begin
            dollar_st = 1'b0;
            add_byte(sws_pkg::CH_DOLLAR);
         end
         if (esc_st == sws_pkg::PH_HEX) add_error(sws_pkg::ERR_HEX);
         else if (esc_st == sws_pkg::PH_OCT) add_error(sws_pkg::ERR_OCTAL);
         else if (esc_st != sws_pkg::PH_NONE) add_error(sws_pkg::ERR_ESCAPE);
         else close_word();
      end
      if (last) begin
         quote_st = sws_pkg::QM_NONE;
         dollar_st = 1'b0;
         esc_st = sws_pkg::PH_NONE;
         digits_st = 2'd0;
         value_st = 9'd0;
         words_st = '0;
         drop_st = 1'b0;
      end
      for (int k = 0; k < beat_n; k++) begin
         beat_buf[k].last_of_input = (k == beat_n - 1);
         expected_beats.push_back(beat_buf[k]);
      end
   endfunction

   function automatic void check_field(input string name, input logic [7:0] want,
                                       input logic [7:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         errors++;
      end
   endfunction

   // driver
   always @(posedge clock) begin
      req_beat_type item;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap = 0;
         beats_in <= 0;
      end else begin
         if (req_valid && req_ready) begin
            predict_beats(req_in_byte, req_line_end);
            beats_in <= beats_in + 1;
            req_gap = calm ? 0 : $urandom_range(0, 6);
         end
         if (!req_valid || req_ready) begin
            if (req_gap != 0) begin
               req_gap--;
               req_valid <= 1'b0;
            end else if (pending.size() != 0) begin
               item = pending.pop_front();
               req_valid <= 1'b1;
               req_in_byte <= item.in_byte;
               req_line_end <= item.line_end;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off so the block backs up into its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (req_valid && req_ready && beats_in % 256 == 200) begin
         hold_left <= 64;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end
   end

   // monitor
   always @(posedge clock) begin
      sws_pkg::result_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap = 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_beats.size() == 0) begin
               $error("result beat with nothing expected: byte %0h", rsp_out_byte);
               errors++;
            end else begin
               want = expected_beats.pop_front();
               check_field("out_byte", want.out_byte, rsp_out_byte);
               check_field("byte_valid", 8'(want.byte_valid), 8'(rsp_byte_valid));
               check_field("word_end", 8'(want.word_end), 8'(rsp_word_end));
               check_field("error_code", 8'(want.error_code), 8'(rsp_error_code));
               check_field("last_of_input", 8'(want.last_of_input), 8'(rsp_last_of_input));
            end
            rsp_gap = calm ? 0 : $urandom_range(0, 6);
         end else if (rsp_gap != 0) begin
            rsp_gap--;
         end
         rsp_ready <= (rsp_gap == 0) && (hold_left == 0);
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) ||
          (csr_valid && csr_ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == STALL_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic put(input logic [7:0] b);
      pending.push_back('{in_byte: b, line_end: 1'b0});
   endtask

   task automatic put_text(input string s);
      for (int i = 0; i < s.len(); i++) put(s[i]);
   endtask

   task automatic end_line();
      req_beat_type item;
      item = pending.pop_back();
      item.line_end = 1'b1;
      pending.push_back(item);
   endtask

   function automatic logic [7:0] text_byte(input logic [7:0] stop_a, input logic [7:0] stop_b);
      logic [7:0] b;
      do b = 8'($urandom_range(1, 255)); while (b == stop_a || b == stop_b);
      return b;
   endfunction

   task automatic add_escape();
      string simple = "\"'\\abefnrtv";
      string hex = "0123456789abcdefABCDEF";
      string bad = "gkmqzGZ?";
      int r;
      r = $urandom_range(0, 19);
      put(sws_pkg::CH_BSLASH);
      if (r < 7) begin
         put(simple[$urandom_range(0, simple.len() - 1)]);
      end else if (r < 10) begin
         put("c");
         if (r == 9) put(sws_pkg::CH_BSLASH);
         put(text_byte(sws_pkg::CH_BSLASH, sws_pkg::CH_BSLASH));
      end else if (r < 13) begin
         put("x");
         put(hex[$urandom_range(0, hex.len() - 1)]);
         put(hex[$urandom_range(0, hex.len() - 1)]);
      end else if (r < 17) begin
         // a leading digit of 4 to 7 overflows the byte
         put(8'("0" + $urandom_range(0, (r == 16) ? 7 : 3)));
         put(8'("0" + $urandom_range(0, 7)));
         put(8'("0" + $urandom_range(0, 7)));
      end else if (r == 17) begin
         put(bad[$urandom_range(0, bad.len() - 1)]);
      end else if (r == 18) begin
         put("x");
         if ($urandom_range(0, 1) == 1) put(hex[$urandom_range(0, hex.len() - 1)]);
         put(bad[$urandom_range(0, bad.len() - 1)]);
      end else begin
         put(8'("0" + $urandom_range(0, 3)));
         if ($urandom_range(0, 1) == 1) put(8'("0" + $urandom_range(0, 7)));
         put(8'("8" + $urandom_range(0, 1)));
      end
   endtask

   task automatic add_line();
      string          seps = " \t\n";
      token_kind_type kind;
      int             n;
      int             r;
      logic           cut;
      logic [7:0]     b;
      n = $urandom_range(1, 6);
      cut = 1'b0;
      for (int t = 0; t < n && !cut; t++) begin
         r = $urandom_range(0, 99);
         kind = r < 25 ? TOK_PLAIN : r < 45 ? TOK_SPACE : r < 55 ? TOK_SINGLE :
                r < 67 ? TOK_DOUBLE : r < 82 ? TOK_ANSI : r < 88 ? TOK_BSLASH :
                r < 93 ? TOK_DOLLAR : r < 97 ? TOK_NOISE : TOK_CUT;
         case (kind)
            TOK_PLAIN: begin
               repeat ($urandom_range(1, 3)) begin
                  do b = 8'($urandom_range(1, 255));
                  while (b == sws_pkg::CH_SQUOTE || b == sws_pkg::CH_DQUOTE ||
                         b == sws_pkg::CH_DOLLAR || b == sws_pkg::CH_BSLASH ||
                         b == sws_pkg::CH_SPACE || b == sws_pkg::CH_TAB ||
                         b == sws_pkg::CH_NL);
                  put(b);
               end
            end
            TOK_SPACE: begin
               repeat ($urandom_range(1, 2)) put(seps[$urandom_range(0, 2)]);
            end
            TOK_SINGLE: begin
               put(sws_pkg::CH_SQUOTE);
               repeat ($urandom_range(0, 4))
                  put(text_byte(sws_pkg::CH_SQUOTE, sws_pkg::CH_SQUOTE));
               if ($urandom_range(0, 7) != 0) put(sws_pkg::CH_SQUOTE);
            end
            TOK_DOUBLE: begin
               put(sws_pkg::CH_DQUOTE);
               repeat ($urandom_range(0, 4)) begin
                  r = $urandom_range(0, 19);
                  if (r < 14) begin
                     put(text_byte(sws_pkg::CH_DQUOTE, sws_pkg::CH_BSLASH));
                  end else begin
                     put(sws_pkg::CH_BSLASH);
                     if (r < 17) put(sws_pkg::CH_DQUOTE);
                     else if (r < 19) put(sws_pkg::CH_NL);
                     else put(text_byte(sws_pkg::CH_DQUOTE, sws_pkg::CH_NL));
                  end
               end
               if ($urandom_range(0, 7) != 0) put(sws_pkg::CH_DQUOTE);
            end
            TOK_ANSI: begin
               put(sws_pkg::CH_DOLLAR);
               put(sws_pkg::CH_SQUOTE);
               repeat ($urandom_range(0, 4)) begin
                  if ($urandom_range(0, 1) == 1) add_escape();
                  else put(text_byte(sws_pkg::CH_SQUOTE, sws_pkg::CH_BSLASH));
               end
               if ($urandom_range(0, 7) != 0) put(sws_pkg::CH_SQUOTE);
            end
            TOK_BSLASH: begin
               put(sws_pkg::CH_BSLASH);
               put(($urandom_range(0, 3) == 0) ? sws_pkg::CH_NL :
                   text_byte(sws_pkg::CH_BSLASH, sws_pkg::CH_BSLASH));
            end
            TOK_DOLLAR: put(sws_pkg::CH_DOLLAR);
            TOK_NOISE: put(8'($urandom_range(0, 255)));
            default: begin
               // line stops inside an escape
               if ($urandom_range(0, 3) == 0) begin
                  put(sws_pkg::CH_BSLASH);
               end else begin
                  put(sws_pkg::CH_DOLLAR);
                  put(sws_pkg::CH_SQUOTE);
                  add_escape();
                  void'(pending.pop_back());
               end
               cut = 1'b1;
            end
         endcase
      end
      if ($urandom_range(0, 11) == 0) begin
         pending.push_back('{in_byte: 8'h00, line_end: 1'($urandom_range(0, 1))});
      end else begin
         end_line();
      end
   endtask

   task automatic drain();
      while (pending.size() != 0 || req_valid || expected_beats.size() != 0) @(negedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_limit(input logic [15:0] v);
      @(posedge clock);
      csr_max_words <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      limit_words = v;
   endtask

   initial begin
      logic [15:0] limits[6];
      limits = '{16'd1, 16'd0, 16'd65535, 16'd2, 16'd512, 16'd2};
      limits[3] = 16'($urandom_range(2, 8));
      limits[5] = 16'($urandom_range(2, 8));
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      put_text("a\"\\\"b\"$");
      end_line();
      put_text("\\\n\t");
      end_line();
      put(sws_pkg::CH_SQUOTE);
      put(8'hff);
      end_line();
      put(8'h00);
      put_text("$'\\477'");
      end_line();
      put_text("$'\\c\\a\\x4");
      end_line();

      for (int p = 0; p < 6; p++) begin
         drain();
         write_limit(limits[p]);
         calm = (p % 3 == 1);
         while (pending.size() < 100) add_line();
      end

      drain();
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
